>>> rtl/sndag_pkg.sv
package sndag_pkg;

	// dimensions and field widths
	localparam int MAX_DIMS     = 4;
	localparam int SIZE_WIDTH   = 16;
	localparam int STRIDE_WIDTH = 16;
	localparam int OFFSET_WIDTH = 40;
	localparam int CFG_WIDTH    = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int DIM_CNT_W    = 3;

	// unsigned index (zero-extended) times signed stride
	localparam int PROD_WIDTH   = SIZE_WIDTH + STRIDE_WIDTH + 1;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = ((2 * OFFSET_WIDTH + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDES = 3'd6;

	typedef logic [SIZE_WIDTH-1:0]          size_t;
	typedef logic signed [OFFSET_WIDTH-1:0] offset_t;

endpackage

>>> rtl/strided_nd_address_generator_unit.sv
// Strided N-dimensional address generator: each word accepted on s_axis asks
// for one (source, destination) element offset pair, returned as one word on
// m_axis. The multi-index walks the active dimensions in row-major order, the
// last active dimension fastest, and wraps to zero after the final element,
// which is marked with tlast; with dim_count zero every word returns offsets
// zero with tlast set. Bit 0 of s_axis_tdata set restarts the walk at index
// zero before the pair is formed. One word is accepted every clock cycle
// under no backpressure. The source and destination index-times-stride
// multipliers of each dimension work in the accepting cycle and are
// registered there (stage 1); the adder tree then feeds the output register
// once it is free, and the pair is on m_axis from that register. Offsets are
// formed from the live counters and strides, so configuration (dim_count,
// sizes, strides) may be rewritten between traversals without moving the
// index; writes must only be made while no request is in flight. Zero sizes
// count as one, dim_count above four counts as four, and offsets wrap at
// 40 bits.
module strided_nd_address_generator_unit
	import sndag_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_WIDTH-1:0]    cfg_data,

	// request stream
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [0] restart, rest zero

	// offset pair stream
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [39:0] src_offset, [79:40] dst_offset
	output logic                    m_axis_tlast    // last
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [DIM_CNT_W-1:0]  dim_count_q;
	size_t                 size_q [MAX_DIMS];
	logic [CFG_WIDTH-1:0]  src_strides_q;
	logic [CFG_WIDTH-1:0]  dst_strides_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q   <= DIM_CNT_W'(1);
			for (int d = 0; d < MAX_DIMS; d++) begin
				size_q[d] <= SIZE_WIDTH'(1);
			end
			src_strides_q <= '0;
			dst_strides_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIM_COUNT:   dim_count_q   <= cfg_data[DIM_CNT_W-1:0];
				REG_SIZE_DIM0:   size_q[0]     <= cfg_data[SIZE_WIDTH-1:0];
				REG_SIZE_DIM1:   size_q[1]     <= cfg_data[SIZE_WIDTH-1:0];
				REG_SIZE_DIM2:   size_q[2]     <= cfg_data[SIZE_WIDTH-1:0];
				REG_SIZE_DIM3:   size_q[3]     <= cfg_data[SIZE_WIDTH-1:0];
				REG_SRC_STRIDES: src_strides_q <= cfg_data;
				REG_DST_STRIDES: dst_strides_q <= cfg_data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// active dimension count, saturated
	logic [DIM_CNT_W-1:0] act_dims;
	assign act_dims = (dim_count_q > DIM_CNT_W'(MAX_DIMS)) ?
		DIM_CNT_W'(MAX_DIMS) : dim_count_q;

	// ------------------------------------------------------------------
	// pipeline handshake: s1 holds products, s2 is the output register
	// ------------------------------------------------------------------
	logic valid_s1;
	logic load_s2;
	logic load_s1;
	logic in_fire;

	assign load_s2       = !m_axis_tvalid || m_axis_tready;
	assign load_s1       = !valid_s1 || load_s2;
	assign s_axis_tready = load_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	logic restart;
	assign restart = s_axis_tdata[0];

	// ------------------------------------------------------------------
	// index counters and advance
	// ------------------------------------------------------------------
	size_t idx_q   [MAX_DIMS];
	size_t idx_cur [MAX_DIMS];   // index after an optional restart
	size_t idx_nxt [MAX_DIMS];
	size_t extent  [MAX_DIMS];
	logic  at_end  [MAX_DIMS];
	logic  active  [MAX_DIMS];
	logic  is_last;
	logic  carry;

	always_comb begin
		is_last = 1'b1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			idx_cur[d] = restart ? '0 : idx_q[d];
			extent[d]  = (size_q[d] == '0) ? SIZE_WIDTH'(1) : size_q[d];
			// counter past its extent (after a resize) also counts as at end
			at_end[d]  = !(({1'b0, idx_cur[d]} + (SIZE_WIDTH+1)'(1)) <
				{1'b0, extent[d]});
			active[d]  = (DIM_CNT_W'(d) < act_dims);
			if (active[d] && !at_end[d]) begin
				is_last = 1'b0;
			end
		end
	end

	// ripple carry from the fastest active dimension toward dimension zero
	always_comb begin
		carry = 1'b1;
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			idx_nxt[d] = idx_cur[d];
			if (active[d] && carry) begin
				if (at_end[d]) begin
					idx_nxt[d] = '0;
				end else begin
					idx_nxt[d] = idx_cur[d] + SIZE_WIDTH'(1);
					carry      = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				idx_q[d] <= '0;
			end
		end else if (in_fire) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				idx_q[d] <= idx_nxt[d];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: per-dimension index times signed stride
	// ------------------------------------------------------------------
	offset_t src_prod_d  [MAX_DIMS];
	offset_t dst_prod_d  [MAX_DIMS];
	offset_t src_prod_s1 [MAX_DIMS];
	offset_t dst_prod_s1 [MAX_DIMS];
	logic    last_s1;

	logic signed [PROD_WIDTH-1:0]   src_mul [MAX_DIMS];
	logic signed [PROD_WIDTH-1:0]   dst_mul [MAX_DIMS];
	logic signed [STRIDE_WIDTH-1:0] src_stride [MAX_DIMS];
	logic signed [STRIDE_WIDTH-1:0] dst_stride [MAX_DIMS];

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			src_stride[d] = src_strides_q[d*STRIDE_WIDTH +: STRIDE_WIDTH];
			dst_stride[d] = dst_strides_q[d*STRIDE_WIDTH +: STRIDE_WIDTH];
			src_mul[d]    = $signed({1'b0, idx_cur[d]}) * src_stride[d];
			dst_mul[d]    = $signed({1'b0, idx_cur[d]}) * dst_stride[d];
			// inactive dimensions add nothing
			src_prod_d[d] = active[d] ? OFFSET_WIDTH'(src_mul[d]) : '0;
			dst_prod_d[d] = active[d] ? OFFSET_WIDTH'(dst_mul[d]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				src_prod_s1[d] <= src_prod_d[d];
				dst_prod_s1[d] <= dst_prod_d[d];
			end
			last_s1 <= is_last;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: sum of products into the output register
	// ------------------------------------------------------------------
	offset_t src_sum;
	offset_t dst_sum;
	offset_t src_offset_s2;
	offset_t dst_offset_s2;
	logic    last_s2;

	always_comb begin
		src_sum = '0;
		dst_sum = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			src_sum = src_sum + src_prod_s1[d];
			dst_sum = dst_sum + dst_prod_s1[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load_s2) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			src_offset_s2 <= src_sum;
			dst_offset_s2 <= dst_sum;
			last_s2       <= last_s1;
		end
	end

	assign m_axis_tdata = {dst_offset_s2, src_offset_s2};
	assign m_axis_tlast = last_s2;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// both stages full and the output stalled: no new request may enter
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("request accepted into a full pipeline");

	// a restart request forms its products from index zero (checked on the first and last dimension)
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && restart) |=>
		(src_prod_s1[0] == '0 && dst_prod_s1[0] == '0 &&
		 src_prod_s1[MAX_DIMS-1] == '0 && dst_prod_s1[MAX_DIMS-1] == '0))
		else $error("restart did not clear the index");

	// a pair moved out of stage 1 lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> m_axis_tvalid)
		else $error("pair lost between stage 1 and the output register");

endmodule
